// ===== hw/rtl/i2csb_pkg.sv =====
// ----------------------------------------------------------------------------
// i2csb_pkg
// Shared types and constants of the I2C slave buffer engine.
// ----------------------------------------------------------------------------
package i2csb_pkg;

  localparam int BUF_DEPTH_DEFAULT = 32;
  // Width that holds any buffer index or count up to a depth of 256.
  localparam int IDX_EXT_W = 9;

  typedef enum logic [3:0] {
    FUNC_ADDR        = 4'd0,
    FUNC_RXDATA      = 4'd1,
    FUNC_STOP        = 4'd2,
    FUNC_TXDONE      = 4'd3,
    FUNC_ERRSTOP     = 4'd4,
    FUNC_ARBLOST     = 4'd5,
    FUNC_UNKNOWN     = 4'd6,
    FUNC_LOADREPLY   = 4'd7,
    FUNC_STARTREPLY  = 4'd8,
    FUNC_READRX      = 4'd9
  } func_t;

  typedef enum logic [2:0] {
    MODE_IDLE         = 3'd0,
    MODE_RECEIVING    = 3'd1,
    MODE_RECEIVED     = 3'd2,
    MODE_READ_PENDING = 3'd3,
    MODE_SENDING      = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    CFG_OWN_ADDRESS     = 2'd0,
    CFG_RX_LIMIT        = 2'd1,
    CFG_REPLY_PRELOADED = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [3:0] func;
    logic [7:0] bus_byte;
    logic [4:0] buf_index;
    logic [7:0] reply_byte;
    logic [5:0] reply_length;
  } req_t;

  typedef struct packed {
    logic       ack;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       hold_clock;
    logic       bus_reset;
    logic       fault;
    logic [2:0] mode;
    logic       message_ready;
    logic [5:0] rx_count;
    logic [7:0] rx_byte;
  } rsp_t;

  typedef struct packed {
    logic [1:0] index;
    logic [6:0] value;
  } cfg_t;

  // Result of the decode stage; memory bytes are merged in as it moves to the output register.
  typedef struct packed {
    logic       ack;
    logic       tx_valid;
    logic       tx_sel;
    logic       hold_clock;
    logic       bus_reset;
    logic       fault;
    logic [2:0] mode;
    logic       message_ready;
    logic [5:0] rx_count;
    logic       rx_sel;
  } stage_t;

endpackage

// ===== hw/rtl/i2csb_chan_if.sv =====
// ----------------------------------------------------------------------------
// i2csb_chan_if
// Valid/ready channel carrying one payload struct.
// ----------------------------------------------------------------------------
interface i2csb_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/i2csb_mem.sv =====
// ----------------------------------------------------------------------------
// i2csb_mem
// Byte buffer with one write port and one registered read port.
// ----------------------------------------------------------------------------
module i2csb_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/i2c_slave_buffer_engine.sv =====
// A request is taken while the decode stage is empty or moving on. Accepting a
// request loads the decode stage, which moves into the output register when
// that is empty or its response is taken; the response is offered from there.
// The engine sustains one request per cycle while responses are taken. Each
// byte buffer has a single read port, read once per request as it is accepted.
// The output register and the decode stage form a two-entry pipeline, so one
// more request is taken while a finished response waits. Byte buffers need no
// clearing after reset.
// ----------------------------------------------------------------------------
// i2c_slave_buffer_engine
// I2C slave transaction engine: address match, receive buffer, reply buffer
// and mode tracking, one bus or software event per request.
// ----------------------------------------------------------------------------
module i2c_slave_buffer_engine
  import i2csb_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEFAULT
) (
  input logic    clk,
  input logic    rst,
  i2csb_chan_if.sink   req,
  i2csb_chan_if.source rsp,
  i2csb_chan_if.sink   cfg
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam logic [IDX_EXT_W-1:0] DEPTH_X = IDX_EXT_W'(BUF_DEPTH);

  // configuration
  logic [6:0] own_address;
  logic [5:0] rx_limit;
  logic       reply_preloaded;

  // engine state
  mode_t      mode;
  mode_t      mode_next;
  logic [5:0] rx_cursor;
  logic [5:0] rx_cursor_next;
  logic [5:0] reply_count;
  logic [5:0] reply_count_next;
  logic [5:0] tx_cursor;
  logic [5:0] tx_cursor_next;

  // pipeline
  logic   a_valid;
  stage_t a;
  stage_t a_next;
  logic   b_valid;
  rsp_t   b;
  logic   accept;
  logic   a_move;

  // buffer ports
  logic          rx_we;
  logic          reply_we;
  logic [AW-1:0] rx_waddr;
  logic [AW-1:0] reply_waddr;
  logic [AW-1:0] rx_raddr;
  logic [AW-1:0] reply_raddr;
  logic [7:0]    rx_rd;
  logic [7:0]    reply_rd;

  logic [IDX_EXT_W-1:0] idx_x;
  logic [IDX_EXT_W-1:0] rx_cursor_x;
  logic [IDX_EXT_W-1:0] tx_cursor_x;
  logic [IDX_EXT_W-1:0] limit_x;
  logic [IDX_EXT_W-1:0] rx_cap_x;
  logic [IDX_EXT_W-1:0] rlen_x;
  logic [IDX_EXT_W-1:0] rlen_cap_x;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address     <= '0;
      rx_limit        <= 6'd32;
      reply_preloaded <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        CFG_OWN_ADDRESS:     own_address     <= cfg.data.value;
        CFG_RX_LIMIT:        rx_limit        <= cfg.data.value[5:0];
        CFG_REPLY_PRELOADED: reply_preloaded <= cfg.data.value[0];
        default: ;
      endcase
    end
  end

  assign a_move    = a_valid && (!b_valid || rsp.ready);
  assign req.ready = !a_valid || a_move;
  assign accept    = req.valid && req.ready;

  assign idx_x       = IDX_EXT_W'(req.data.buf_index);
  assign rx_cursor_x = IDX_EXT_W'(rx_cursor);
  assign tx_cursor_x = IDX_EXT_W'(tx_cursor);
  assign limit_x     = IDX_EXT_W'(rx_limit);
  assign rx_cap_x    = (limit_x > DEPTH_X) ? DEPTH_X : limit_x;
  assign rlen_x      = IDX_EXT_W'(req.data.reply_length);
  assign rlen_cap_x  = (rlen_x > DEPTH_X) ? DEPTH_X : rlen_x;

  assign rx_waddr    = rx_cursor_x[AW-1:0];
  assign reply_waddr = idx_x[AW-1:0];
  assign rx_raddr    = idx_x[AW-1:0];

  always_comb begin
    mode_next        = mode;
    rx_cursor_next   = rx_cursor;
    reply_count_next = reply_count;
    tx_cursor_next   = tx_cursor;
    rx_we            = 1'b0;
    reply_we         = 1'b0;
    reply_raddr      = '0;
    a_next           = '0;

    case (req.data.func)
      FUNC_ADDR: begin
        if (req.data.bus_byte[7:1] == own_address) begin
          a_next.ack = 1'b1;
          if (req.data.bus_byte[0]) begin
            if (mode == MODE_RECEIVED) begin
              if (reply_preloaded) begin
                if (reply_count != '0) begin
                  tx_cursor_next  = 6'd1;
                  a_next.tx_valid = 1'b1;
                  a_next.tx_sel   = 1'b1;
                  mode_next       = MODE_SENDING;
                end else begin
                  a_next.fault = 1'b1;
                end
              end else begin
                mode_next = MODE_READ_PENDING;
              end
            end else begin
              a_next.fault = 1'b1;
            end
          end else begin
            rx_cursor_next = '0;
            mode_next      = MODE_RECEIVING;
          end
        end
      end
      FUNC_RXDATA: begin
        // drop bytes beyond the limit
        if (rx_cursor_x < rx_cap_x) begin
          rx_we          = 1'b1;
          rx_cursor_next = rx_cursor + 6'd1;
        end
        a_next.ack = 1'b1;
      end
      FUNC_STOP: mode_next = MODE_RECEIVED;
      FUNC_TXDONE: begin
        a_next.tx_valid = 1'b1;
        reply_raddr     = tx_cursor_x[AW-1:0];
        if (tx_cursor < reply_count) begin
          a_next.tx_sel  = 1'b1;
          tx_cursor_next = tx_cursor + 6'd1;
          if (tx_cursor_next >= reply_count) begin
            mode_next = MODE_IDLE;
          end
        end
      end
      FUNC_ERRSTOP: ;
      FUNC_ARBLOST: mode_next = MODE_IDLE;
      FUNC_LOADREPLY: reply_we = (idx_x < DEPTH_X);
      FUNC_STARTREPLY: begin
        if (mode != MODE_RECEIVED && mode != MODE_READ_PENDING) begin
          a_next.fault = 1'b1;
        end
        reply_count_next = rlen_cap_x[5:0];
        tx_cursor_next   = 6'd1;
        mode_next        = MODE_SENDING;
        a_next.ack       = 1'b1;
        a_next.tx_valid  = 1'b1;
        if (rlen_cap_x != '0) begin
          a_next.tx_sel = 1'b1;
        end else begin
          a_next.fault = 1'b1;
        end
      end
      FUNC_READRX: a_next.rx_sel = (idx_x < DEPTH_X);
      FUNC_UNKNOWN: a_next.bus_reset = 1'b1;
      default: a_next.bus_reset = 1'b1;
    endcase

    a_next.mode          = mode_next;
    a_next.hold_clock    = (mode_next == MODE_READ_PENDING);
    a_next.message_ready = (mode_next == MODE_RECEIVED);
    a_next.rx_count      = rx_cursor_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      rx_cursor   <= '0;
      reply_count <= '0;
      tx_cursor   <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      rx_cursor   <= rx_cursor_next;
      reply_count <= reply_count_next;
      tx_cursor   <= tx_cursor_next;
    end
  end

  i2csb_mem #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_rx_mem (
    .clk   (clk),
    .we    (accept && rx_we),
    .waddr (rx_waddr),
    .wdata (req.data.bus_byte),
    .re    (accept),
    .raddr (rx_raddr),
    .rdata (rx_rd)
  );

  i2csb_mem #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_reply_mem (
    .clk   (clk),
    .we    (accept && reply_we),
    .waddr (reply_waddr),
    .wdata (req.data.reply_byte),
    .re    (accept),
    .raddr (reply_raddr),
    .rdata (reply_rd)
  );

  // decode stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a <= a_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_move) begin
      b_valid <= 1'b1;
    end else if (rsp.ready) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b.ack           <= a.ack;
      b.tx_valid      <= a.tx_valid;
      b.tx_byte       <= a.tx_sel ? reply_rd : 8'd0;
      b.hold_clock    <= a.hold_clock;
      b.bus_reset     <= a.bus_reset;
      b.fault         <= a.fault;
      b.mode          <= a.mode;
      b.message_ready <= a.message_ready;
      b.rx_count      <= a.rx_count;
      b.rx_byte       <= a.rx_sel ? rx_rd : 8'd0;
    end
  end

  assign rsp.valid = b_valid;
  assign rsp.data  = b;

endmodule

// ===== tb/i2c_slave_buffer_engine_chk.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_slave_buffer_engine_chk
// Watches the request, response and configuration channels of the I2C slave
// engine, tracks the slave state on every accepted request and compares each
// accepted response, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module i2c_slave_buffer_engine_chk
  import i2csb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req_data,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp_data,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  cfg_t cfg_data,
  output int   fail_count,
  output int   pending
);

  localparam int DEPTH = BUF_DEPTH_DEFAULT;

  // configuration copy
  logic [6:0] own_addr;
  logic [5:0] rx_limit;
  logic       preloaded;

  // slave state copy
  mode_t      link_mode;
  logic [5:0] rx_cursor;
  logic [5:0] reply_count;
  logic [5:0] tx_cursor;
  logic [7:0] rx_mem [DEPTH];
  logic [7:0] reply_mem [DEPTH];

  rsp_t due_results[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [5:0] cap_depth(logic [5:0] v);
    return (v > 6'(DEPTH)) ? 6'(DEPTH) : v;
  endfunction

  // Apply one bus or software event to the state copy and return its response.
  function automatic rsp_t engine_step(req_t r);
    rsp_t o;
    o = '0;
    case (r.func)
      FUNC_ADDR: begin
        if (r.bus_byte[7:1] == own_addr) begin
          o.ack = 1'b1;
          if (r.bus_byte[0]) begin
            if (link_mode == MODE_RECEIVED) begin
              if (preloaded) begin
                if (reply_count > 0) begin
                  tx_cursor = 6'd1;
                  o.tx_valid = 1'b1;
                  o.tx_byte = reply_mem[0];
                  link_mode = MODE_SENDING;
                end else begin
                  o.fault = 1'b1;
                end
              end else begin
                link_mode = MODE_READ_PENDING;
              end
            end else begin
              o.fault = 1'b1;
            end
          end else begin
            rx_cursor = '0;
            link_mode = MODE_RECEIVING;
          end
        end
      end
      FUNC_RXDATA: begin
        // drop bytes beyond the limit
        if (rx_cursor < cap_depth(rx_limit)) begin
          rx_mem[rx_cursor[4:0]] = r.bus_byte;
          rx_cursor = rx_cursor + 6'd1;
        end
        o.ack = 1'b1;
      end
      FUNC_STOP:    link_mode = MODE_RECEIVED;
      FUNC_TXDONE: begin
        o.tx_valid = 1'b1;
        if (tx_cursor < reply_count) begin
          o.tx_byte = reply_mem[tx_cursor[4:0]];
          tx_cursor = tx_cursor + 6'd1;
          if (tx_cursor >= reply_count) link_mode = MODE_IDLE;
        end
      end
      FUNC_ERRSTOP: ;
      FUNC_ARBLOST: link_mode = MODE_IDLE;
      FUNC_LOADREPLY: reply_mem[r.buf_index] = r.reply_byte;
      FUNC_STARTREPLY: begin
        if (link_mode != MODE_RECEIVED && link_mode != MODE_READ_PENDING) o.fault = 1'b1;
        reply_count = cap_depth(r.reply_length);
        tx_cursor = 6'd1;
        link_mode = MODE_SENDING;
        o.ack = 1'b1;
        o.tx_valid = 1'b1;
        if (reply_count > 0) o.tx_byte = reply_mem[0];
        else o.fault = 1'b1;
      end
      FUNC_READRX:  o.rx_byte = rx_mem[r.buf_index];
      default:      o.bus_reset = 1'b1;
    endcase
    o.hold_clock = (link_mode == MODE_READ_PENDING);
    o.mode = link_mode;
    o.message_ready = (link_mode == MODE_RECEIVED);
    o.rx_count = rx_cursor;
    return o;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ERROR %s: expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      own_addr = '0;
      rx_limit = 6'd32;
      preloaded = 1'b0;
      link_mode = MODE_IDLE;
      rx_cursor = '0;
      reply_count = '0;
      tx_cursor = '0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_data.index))
          CFG_OWN_ADDRESS:     own_addr = cfg_data.value;
          CFG_RX_LIMIT:        rx_limit = cfg_data.value[5:0];
          CFG_REPLY_PRELOADED: preloaded = cfg_data.value[0];
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t ERROR unexpected response: expected none actual %0h", $time,
                   rsp_data);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("ack", want.ack, rsp_data.ack);
          check_field("tx_valid", want.tx_valid, rsp_data.tx_valid);
          check_field("tx_byte", want.tx_byte, rsp_data.tx_byte);
          check_field("hold_clock", want.hold_clock, rsp_data.hold_clock);
          check_field("bus_reset", want.bus_reset, rsp_data.bus_reset);
          check_field("fault", want.fault, rsp_data.fault);
          check_field("mode", want.mode, rsp_data.mode);
          check_field("message_ready", want.message_ready, rsp_data.message_ready);
          check_field("rx_count", want.rx_count, rsp_data.rx_count);
          check_field("rx_byte", want.rx_byte, rsp_data.rx_byte);
        end
      end
      if (req_valid && req_ready) due_results.push_back(engine_step(req_data));
    end
    pending = due_results.size();
  end

endmodule

// ===== tb/i2c_slave_buffer_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_slave_buffer_engine_tb
// Drives bus and software events into the I2C slave engine: a buffer fill,
// directed corner cases, then random write and read transactions under
// several address, limit and preload settings, with random stalls on both
// channels. The checker beside the engine does all prediction and compare.
// ----------------------------------------------------------------------------
module i2c_slave_buffer_engine_tb;
  import i2csb_pkg::*;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   req_count = 0;
  int   burst_left = 0;
  bit   pressure_go = 1'b0;

  // settings last written, used to aim address bytes and byte counts
  logic [6:0] cur_addr = '0;
  logic [5:0] cur_limit = 6'd32;
  logic       cur_preload = 1'b0;

  i2csb_chan_if #(.payload_t(req_t)) req_ch ();
  i2csb_chan_if #(.payload_t(rsp_t)) rsp_ch ();
  i2csb_chan_if #(.payload_t(cfg_t)) cfg_ch ();

  i2c_slave_buffer_engine u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  i2c_slave_buffer_engine_chk u_chk (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_ch.valid),
    .req_ready  (req_ch.ready),
    .req_data   (req_ch.data),
    .rsp_valid  (rsp_ch.valid),
    .rsp_ready  (rsp_ch.ready),
    .rsp_data   (rsp_ch.data),
    .cfg_valid  (cfg_ch.valid),
    .cfg_ready  (cfg_ch.ready),
    .cfg_data   (cfg_ch.data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

  // mostly short idle stretches, a few long ones
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // response side: random stalls, long ready runs, and one long hold-off
  initial begin
    int  on_len;
    int  off_len;
    bit  pressure_done;
    pressure_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      on_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                           : $urandom_range(1, 12);
      rsp_ch.ready <= 1'b1;
      repeat (on_len) @(posedge clk);
      if (pressure_go && !pressure_done) begin
        off_len = 150;
        pressure_done = 1'b1;
      end else begin
        off_len = idle_len();
      end
      if (off_len > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (off_len) @(posedge clk);
      end
    end
  end

  // Send one request; a negative argument means a random field value.
  task automatic send(input func_t f, input int bus_b = -1, input int idx = -1,
                      input int rbyte = -1, input int rlen = -1);
    req_t r;
    int   gap;
    r.func = f;
    r.bus_byte = (bus_b < 0) ? 8'($urandom) : 8'(bus_b);
    r.buf_index = (idx < 0) ? 5'($urandom) : 5'(idx);
    r.reply_byte = (rbyte < 0) ? 8'($urandom) : 8'(rbyte);
    r.reply_length = (rlen < 0) ? 6'($urandom_range(0, 32)) : 6'(rlen);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 99) < 8) begin
      burst_left = $urandom_range(20, 60);
      gap = 0;
    end else begin
      gap = idle_len();
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
    req_count++;
  endtask

  // Drop valid and wait until every response has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [6:0] addr, input logic [5:0] limit,
                            input logic preload);
    cfg_t w [3];
    w[0] = '{index: CFG_OWN_ADDRESS, value: addr};
    w[1] = '{index: CFG_RX_LIMIT, value: {1'b0, limit}};
    w[2] = '{index: CFG_REPLY_PRELOADED, value: {6'd0, preload}};
    for (int i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.data <= w[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    cur_addr = addr;
    cur_limit = limit;
    cur_preload = preload;
  endtask

  function automatic int pick_len();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 0;
    if (p == 1) return 32;
    return $urandom_range(1, 6);
  endfunction

  // master write: address, data bytes, then mostly a stop
  task automatic write_xfer();
    int nbytes;
    if ($urandom_range(0, 9) == 0) send(FUNC_ADDR, {7'($urandom), 1'b0});
    else send(FUNC_ADDR, {cur_addr, 1'b0});
    nbytes = $urandom_range(0, int'(cur_limit) + 2);
    repeat (nbytes) send(FUNC_RXDATA);
    if ($urandom_range(0, 7) == 0) send(FUNC_ARBLOST);
    else send(FUNC_STOP);
  endtask

  // master read: address, reply set-up where needed, transmitted bytes
  task automatic read_xfer();
    int len;
    int ntx;
    if (cur_preload && $urandom_range(0, 3) == 0) begin
      send(FUNC_STARTREPLY, -1, -1, -1, pick_len());
      send(FUNC_STOP);
    end
    send(FUNC_ADDR, {cur_addr, 1'b1});
    if (cur_preload) begin
      ntx = $urandom_range(0, 5);
    end else begin
      repeat ($urandom_range(0, 2)) send(FUNC_LOADREPLY);
      len = pick_len();
      send(FUNC_STARTREPLY, -1, -1, -1, len);
      ntx = len + $urandom_range(0, 2) - 1;
      if (ntx < 0) ntx = 0;
    end
    repeat (ntx) send(FUNC_TXDONE);
    case ($urandom_range(0, 2))
      0: send(FUNC_STOP);
      1: send(FUNC_ARBLOST);
      default: ;
    endcase
  endtask

  task automatic run_random(input int n);
    int start;
    int p;
    start = req_count;
    while (req_count - start < n) begin
      p = $urandom_range(0, 99);
      if (p < 45) begin
        write_xfer();
        read_xfer();
      end else if (p < 65) begin
        write_xfer();
        repeat ($urandom_range(1, 3)) send(FUNC_READRX);
      end else if (p < 80) begin
        repeat ($urandom_range(1, 4)) send(FUNC_LOADREPLY);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) == 0) send(func_t'($urandom_range(0, 9)));
          else send(func_t'($urandom_range(0, 9)), {cur_addr, 1'($urandom)});
        end
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill both byte stores so that every later read hits written data
    for (int i = 0; i < 32; i++) send(FUNC_LOADREPLY, -1, i);
    send(FUNC_ADDR, 8'h00);
    repeat (32) send(FUNC_RXDATA);
    send(FUNC_STOP);
    drain();

    set_config(7'h2A, 6'd4, 1'b0);
    send(FUNC_ARBLOST);
    send(FUNC_ADDR, {7'h2B, 1'b0});         // address mismatch
    send(FUNC_ADDR, {7'h2A, 1'b1});         // read while not received
    send(FUNC_ADDR, {7'h2A, 1'b0});
    send(FUNC_RXDATA, 8'h00);
    send(FUNC_RXDATA, 8'hFF);
    send(FUNC_RXDATA, 8'h5A);
    send(FUNC_RXDATA, 8'hA5);
    send(FUNC_RXDATA, 8'h3C);               // beyond the limit, dropped
    send(FUNC_ERRSTOP);
    send(FUNC_STOP);
    send(FUNC_READRX, -1, 0);
    send(FUNC_READRX, -1, 31);
    send(FUNC_ADDR, {7'h2A, 1'b1});         // read pending, clock held
    send(FUNC_STARTREPLY, -1, -1, -1, 3);
    repeat (3) send(FUNC_TXDONE);           // last one runs past the end
    send(FUNC_STARTREPLY, -1, -1, -1, 32);  // wrong mode
    send(FUNC_STARTREPLY, -1, -1, -1, 0);   // empty reply
    send(FUNC_UNKNOWN);
    send(FUNC_LOADREPLY, -1, 0, 8'hFF);
    send(FUNC_LOADREPLY, -1, 31, 8'h00);
    drain();

    set_config(7'h2A, 6'd32, 1'b1);
    send(FUNC_STOP);
    send(FUNC_ADDR, {7'h2A, 1'b1});         // preloaded but reply is empty
    send(FUNC_STARTREPLY, -1, -1, -1, 2);
    send(FUNC_STOP);
    send(FUNC_ADDR, {7'h2A, 1'b1});         // preloaded read sends at once
    send(FUNC_TXDONE);
    drain();

    pressure_go = 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_config(7'h7F, 6'd32, 1'b0);
        1: set_config(7'h00, 6'd0, 1'b1);
        2: set_config(7'($urandom), 6'd1, 1'b0);
        3: set_config(7'($urandom), 6'($urandom_range(2, 8)), 1'b1);
        default: set_config(7'($urandom), 6'($urandom_range(0, 32)), 1'($urandom));
      endcase
      run_random(65);
      drain();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== i2c_slave_buffer_engine.f =====
hw/rtl/i2csb_pkg.sv
hw/rtl/i2csb_chan_if.sv
hw/rtl/i2csb_mem.sv
hw/rtl/i2c_slave_buffer_engine.sv
tb/i2c_slave_buffer_engine_chk.sv
tb/i2c_slave_buffer_engine_tb.sv
